// ===== design/gou_pkg.sv =====
// Shared types, widths and arithmetic step functions of the optimizer update engine.
// No dependencies; imported by gradient_optimizer_update and its bench.
package gou_pkg;

  localparam int FRAC_BITS = 24;                     // binary point of all Q formats
  localparam int DW        = 32;                     // element width
  localparam int CW        = 24;                     // config data width
  localparam int QW        = FRAC_BITS + 1;          // fraction including one
  localparam int SQ_W      = 2 * DW - FRAC_BITS;     // g^2 after the product shift
  localparam int RW        = (DW + FRAC_BITS) / 2;   // root width of sqrt(vhat << F)
  localparam int DEN_W     = RW + 1;                 // root + epsilon
  localparam int NUM_W     = CW + DW;                // lr * |mhat|
  localparam int PM_W      = QW + DW + 1;            // signed decay products
  localparam int PSQ_W     = QW + SQ_W;              // (1-d) * g^2
  localparam int PAC_W     = QW + DW;                // d * acc

  localparam logic [QW-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [1:0] {
    MODE_SGD     = 2'd0,
    MODE_RMSPROP = 2'd1,
    MODE_ADAM    = 2'd2,
    MODE_PASS    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE          = 3'd0,
    REG_LEARNING_RATE = 3'd1,
    REG_EPSILON       = 3'd2,
    REG_RHO           = 3'd3,
    REG_BETA_ONE      = 3'd4,
    REG_BETA_TWO      = 3'd5
  } reg_idx_t;

  // fields that ride along every stage after the moment update
  typedef struct packed {
    logic          vld;
    mode_t         mode;
    logic [DW-1:0] w;
    logic [DW-1:0] m_out;
    logic [DW-1:0] v_out;
    logic          flg;
    logic          neg;     // sign of the weight delta
    logic [DW-1:0] d0;      // sgd delta magnitude
  } side_t;

  typedef struct packed {
    logic          vld;
    mode_t         mode;
    logic [DW-1:0] w;
    logic [DW-1:0] g;
    logic [DW-1:0] m;
    logic [DW-1:0] v;
    logic [QW-1:0] p1;
    logic [QW-1:0] p2;
  } s0_t;

  typedef struct packed {
    logic                   vld;
    mode_t                  mode;
    logic [DW-1:0]          w;
    logic [DW-1:0]          m;
    logic [DW-1:0]          v;
    logic                   gneg;
    logic [DW-1:0]          magg;
    logic [QW-1:0]          omd;
    logic [SQ_W-1:0]        sq;
    logic [PAC_W-1:0]       pacc;
    logic signed [PM_W-1:0] pm;
    logic signed [PM_W-1:0] pg;
    logic [NUM_W-1:0]       lrg;
    logic [QW-1:0]          c1;
    logic [QW-1:0]          c2;
  } s1_t;

  typedef struct packed {
    logic                 vld;
    mode_t                mode;
    logic [DW-1:0]        w;
    logic [DW-1:0]        m;
    logic [DW-1:0]        v;
    logic                 gneg;
    logic [DW-1:0]        magg;
    logic [DW-1:0]        d0;
    logic [PSQ_W-1:0]     psq;
    logic [PAC_W-1:0]     pacc;
    logic signed [PM_W:0] msum;
    logic [QW-1:0]        c1;
    logic [QW-1:0]        c2;
  } s2_t;

  typedef struct packed {
    side_t         side;
    logic [DW-1:0] xmag;
    logic [DW-1:0] vval;
    logic [QW-1:0] c1;
    logic [QW-1:0] c2;
  } s3_t;

  // bias correction dividers, one quotient bit per stage
  typedef struct packed {
    side_t            side;
    logic [QW-1:0]    c1;
    logic [QW-1:0]    c2;
    logic             mov;
    logic             vov;
    logic [DEN_W-1:0] mrem;
    logic [DEN_W-1:0] vrem;
    logic [DW-1:0]    mlow;
    logic [DW-1:0]    vlow;
    logic [DW-1:0]    mq;
    logic [DW-1:0]    vq;
  } cdiv_t;

  // square root, one root bit per stage
  typedef struct packed {
    side_t           side;
    logic [NUM_W-1:0] num;
    logic [2*RW-1:0] rad;
    logic [RW+1:0]   rem;
    logic [RW-1:0]   root;
  } sqrt_t;

  // step divider, one quotient bit per stage
  typedef struct packed {
    side_t            side;
    logic [DEN_W-1:0] den;
    logic             dz;
    logic             ov;
    logic [DEN_W-1:0] rem;
    logic [DW-1:0]    low;
    logic [DW-1:0]    q;
  } fdiv_t;

  function automatic logic [QW-1:0] clamp_frac(logic [CW-1:0] v);
    logic [QW-1:0] x;
    x = QW'(v);
    return (x > ONE_Q) ? ONE_Q : x;
  endfunction

  // restoring division step: {new remainder, quotient bit}; needs rem < den
  function automatic logic [DEN_W:0] div_step(logic [DEN_W-1:0] rem, logic bin,
                                               logic [DEN_W-1:0] den);
    logic [DEN_W:0] sh;
    logic [DEN_W:0] diff;
    sh   = {rem, bin};
    diff = sh - {1'b0, den};
    if (sh >= {1'b0, den}) begin
      return {diff[DEN_W-1:0], 1'b1};
    end
    return {sh[DEN_W-1:0], 1'b0};
  endfunction

  // digit-by-digit integer square root step: {new remainder, new root}
  function automatic logic [2*RW+1:0] sqrt_step(logic [RW+1:0] rem, logic [RW-1:0] root,
                                                logic [1:0] pair);
    logic [RW+3:0] sh;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    sh    = {rem, pair};
    trial = {2'b00, root, 2'b01};
    diff  = sh - trial;
    if (sh >= trial) begin
      return {diff[RW+1:0], root[RW-2:0], 1'b1};
    end
    return {sh[RW+1:0], root[RW-2:0], 1'b0};
  endfunction

endpackage

// ===== design/gradient_optimizer_update.sv =====
// Optimizer update engine (SGD / RMSProp / Adam) for one Q8.24 parameter element per transfer.
// Depends on gou_pkg for widths, stage structs and the divide / square root step functions.
//
// Pipeline: a front end of 4 registers, a bias-correction divide of 33, a square root of 29,
//   a step divide of 33 and an output register.
// Throughput: one element per cycle unless halted; every stage advances together and halts only
//   while the output register holds an untaken result and the last divider stage is full.
// Reset (rst_n low, synchronous): pipeline and output empty, registers at their documented
//   defaults, both beta power products back to one.
module gradient_optimizer_update
  import gou_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_weight,
  input  logic signed [31:0]   in_gradient,
  input  logic signed [31:0]   in_first_moment,
  input  logic [31:0]          in_second_moment,
  input  logic                 in_first_of_step,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_new_weight,
  output logic signed [31:0]   out_new_first_moment,
  output logic [31:0]          out_new_second_moment,
  output logic                 out_saturated,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [CW-1:0]        cfg_data
);

  localparam logic [CW-1:0] LR_RST  = CW'(16777);
  localparam logic [CW-1:0] EPS_RST = CW'(1);
  localparam logic [CW-1:0] RHO_RST = CW'(15099494);
  localparam logic [CW-1:0] B1_RST  = CW'(15099494);
  localparam logic [CW-1:0] B2_RST  = CW'(16760439);

  localparam logic [DW-1:0] S_MAX   = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] S_MIN   = {1'b1, {(DW-1){1'b0}}};

  // ---------------------------------------------------------------------------------------------
  // Configuration. Decays are stored already limited to one.
  // ---------------------------------------------------------------------------------------------
  mode_t         mode_r;
  logic [CW-1:0] lr_r;
  logic [CW-1:0] eps_r;
  logic [QW-1:0] rho_r;
  logic [QW-1:0] b1_r;
  logic [QW-1:0] b2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SGD;
      lr_r   <= LR_RST;
      eps_r  <= EPS_RST;
      rho_r  <= clamp_frac(RHO_RST);
      b1_r   <= clamp_frac(B1_RST);
      b2_r   <= clamp_frac(B2_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:          mode_r <= mode_t'(cfg_data[1:0]);
        REG_LEARNING_RATE: lr_r   <= cfg_data;
        REG_EPSILON:       eps_r  <= cfg_data;
        REG_RHO:           rho_r  <= clamp_frac(cfg_data);
        REG_BETA_ONE:      b1_r   <= clamp_frac(cfg_data);
        REG_BETA_TWO:      b2_r   <= clamp_frac(cfg_data);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Flow control: one enable for the whole pipe.
  // ---------------------------------------------------------------------------------------------
  logic   en;
  logic   out_valid_r;
  fdiv_t  fd_r [0:DW];

  assign en       = !fd_r[DW].side.vld || !out_valid_r || out_ready;
  assign in_ready = en;

  // ---------------------------------------------------------------------------------------------
  // Stage 0: input register. The beta powers advance here, in transfer order, on the first
  // element of an Adam step; the element carries the advanced powers.
  // ---------------------------------------------------------------------------------------------
  logic [QW-1:0]   pow1_r, pow2_r, pow1_nxt, pow2_nxt;
  logic [2*QW-1:0] prod1, prod2;
  logic            adv;
  s0_t             s0_r, s0_nxt;

  assign adv   = in_valid && en && (mode_r == MODE_ADAM) && in_first_of_step;
  assign prod1 = pow1_r * b1_r;
  assign prod2 = pow2_r * b2_r;

  always_comb begin
    pow1_nxt = adv ? prod1[FRAC_BITS +: QW] : pow1_r;
    pow2_nxt = adv ? prod2[FRAC_BITS +: QW] : pow2_r;
    s0_nxt.vld  = in_valid;
    s0_nxt.mode = mode_r;
    s0_nxt.w    = in_weight;
    s0_nxt.g    = in_gradient;
    s0_nxt.m    = in_first_moment;
    s0_nxt.v    = in_second_moment;
    s0_nxt.p1   = pow1_nxt;
    s0_nxt.p2   = pow2_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pow1_r <= ONE_Q;
      pow2_r <= ONE_Q;
      s0_r   <= '0;
    end else begin
      pow1_r <= pow1_nxt;
      pow2_r <= pow2_nxt;
      if (en) begin
        s0_r <= s0_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Stage 1: products. g^2, d*acc, the two first-moment terms and lr*|g| for SGD.
  // Correction divisors are one outside Adam, so RMSProp rides the same dividers untouched.
  // ---------------------------------------------------------------------------------------------
  s1_t             s1_r, s1_nxt;
  logic [DW-1:0]   magg;
  logic [2*DW-1:0] gsq;
  logic [QW-1:0]   dsel;

  always_comb begin
    magg = s0_r.g[DW-1] ? (DW'(0) - s0_r.g) : s0_r.g;
    gsq  = magg * magg;
    dsel = (s0_r.mode == MODE_RMSPROP) ? rho_r : b2_r;
    s1_nxt.vld  = s0_r.vld;
    s1_nxt.mode = s0_r.mode;
    s1_nxt.w    = s0_r.w;
    s1_nxt.m    = s0_r.m;
    s1_nxt.v    = s0_r.v;
    s1_nxt.gneg = s0_r.g[DW-1];
    s1_nxt.magg = magg;
    s1_nxt.omd  = ONE_Q - dsel;
    s1_nxt.sq   = gsq[2*DW-1:FRAC_BITS];
    s1_nxt.pacc = dsel * s0_r.v;
    s1_nxt.pm   = $signed({1'b0, b1_r}) * $signed(s0_r.m);
    s1_nxt.pg   = $signed({1'b0, ONE_Q - b1_r}) * $signed(s0_r.g);
    s1_nxt.lrg  = lr_r * magg;
    s1_nxt.c1   = ((s0_r.mode == MODE_ADAM) && (s0_r.p1 != ONE_Q)) ? ONE_Q - s0_r.p1 : ONE_Q;
    s1_nxt.c2   = ((s0_r.mode == MODE_ADAM) && (s0_r.p2 != ONE_Q)) ? ONE_Q - s0_r.p2 : ONE_Q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
    end else if (en) begin
      s1_r <= s1_nxt;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Stage 2: (1-d)*g^2, first-moment sum, SGD delta.
  // ---------------------------------------------------------------------------------------------
  s2_t s2_r, s2_nxt;

  always_comb begin
    s2_nxt.vld  = s1_r.vld;
    s2_nxt.mode = s1_r.mode;
    s2_nxt.w    = s1_r.w;
    s2_nxt.m    = s1_r.m;
    s2_nxt.v    = s1_r.v;
    s2_nxt.gneg = s1_r.gneg;
    s2_nxt.magg = s1_r.magg;
    s2_nxt.d0   = s1_r.lrg[FRAC_BITS +: DW];
    s2_nxt.psq  = s1_r.omd * s1_r.sq;
    s2_nxt.pacc = s1_r.pacc;
    s2_nxt.msum = $signed(s1_r.pm) + $signed(s1_r.pg);
    s2_nxt.c1   = s1_r.c1;
    s2_nxt.c2   = s1_r.c2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r <= '0;
    end else if (en) begin
      s2_r <= s2_nxt;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Stage 3: new moments with saturation, per-mode selection of what goes back.
  // ---------------------------------------------------------------------------------------------
  localparam int MM_W = PM_W + 1 - FRAC_BITS;

  s3_t              s3_r, s3_nxt;
  logic [PSQ_W:0]   vsum;
  logic             vsat;
  logic [DW-1:0]    vnew;
  logic             mneg, msat;
  logic [PM_W:0]    mabs;
  logic [MM_W-1:0]  mmag;
  logic [DW-1:0]    mnmag, mnew;

  always_comb begin
    vsum  = (PSQ_W+1)'(s2_r.pacc) + (PSQ_W+1)'(s2_r.psq);
    vsat  = |vsum[PSQ_W:FRAC_BITS+DW];
    vnew  = vsat ? '1 : vsum[FRAC_BITS +: DW];
    mneg  = s2_r.msum[PM_W];
    mabs  = mneg ? (PM_W+1)'(-s2_r.msum) : (PM_W+1)'(s2_r.msum);
    mmag  = mabs[PM_W:FRAC_BITS];
    msat  = mneg ? (mmag > MM_W'(S_MIN)) : (mmag > MM_W'(S_MAX));
    mnmag = msat ? (mneg ? S_MIN : S_MAX) : mmag[DW-1:0];
    mnew  = mneg ? (DW'(0) - mnmag) : mnmag;

    s3_nxt.side.vld   = s2_r.vld;
    s3_nxt.side.mode  = s2_r.mode;
    s3_nxt.side.w     = s2_r.w;
    s3_nxt.side.d0    = s2_r.d0;
    s3_nxt.side.m_out = s2_r.m;
    s3_nxt.side.v_out = s2_r.v;
    s3_nxt.side.flg   = 1'b0;
    s3_nxt.side.neg   = s2_r.gneg;
    s3_nxt.xmag       = s2_r.magg;
    s3_nxt.vval       = vnew;
    s3_nxt.c1         = s2_r.c1;
    s3_nxt.c2         = s2_r.c2;
    case (s2_r.mode)
      MODE_SGD: ;
      MODE_RMSPROP: begin
        s3_nxt.side.v_out = vnew;
        s3_nxt.side.flg   = vsat;
      end
      MODE_ADAM: begin
        s3_nxt.side.m_out = mnew;
        s3_nxt.side.v_out = vnew;
        s3_nxt.side.flg   = vsat | msat;
        s3_nxt.side.neg   = mneg;
        s3_nxt.xmag       = mnmag;
      end
      default: s3_nxt.side.neg = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r <= '0;
    end else if (en) begin
      s3_r <= s3_nxt;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Bias correction: mhat = |m| * ONE / c1 and vhat = v * ONE / c2. A quotient that would not
  // fit 32 bits is flagged up front and later clipped; otherwise 32 restoring steps.
  // ---------------------------------------------------------------------------------------------
  cdiv_t cd_r [0:DW];
  cdiv_t cd0_nxt;
  logic [FRAC_BITS-1:0] mhi, vhi;

  always_comb begin
    mhi = s3_r.xmag[DW-1 -: FRAC_BITS];
    vhi = s3_r.vval[DW-1 -: FRAC_BITS];
    cd0_nxt.side = s3_r.side;
    cd0_nxt.c1   = s3_r.c1;
    cd0_nxt.c2   = s3_r.c2;
    cd0_nxt.mov  = QW'(mhi) >= s3_r.c1;
    cd0_nxt.vov  = QW'(vhi) >= s3_r.c2;
    cd0_nxt.mrem = cd0_nxt.mov ? '0 : DEN_W'(mhi);
    cd0_nxt.vrem = cd0_nxt.vov ? '0 : DEN_W'(vhi);
    cd0_nxt.mlow = {s3_r.xmag[DW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
    cd0_nxt.vlow = {s3_r.vval[DW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
    cd0_nxt.mq   = '0;
    cd0_nxt.vq   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r[0] <= '0;
    end else if (en) begin
      cd_r[0] <= cd0_nxt;
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_cdiv
    cdiv_t          nxt;
    logic [DEN_W:0] rm, rv;

    always_comb begin
      rm           = div_step(cd_r[k].mrem, cd_r[k].mlow[DW-1], DEN_W'(cd_r[k].c1));
      rv           = div_step(cd_r[k].vrem, cd_r[k].vlow[DW-1], DEN_W'(cd_r[k].c2));
      nxt          = cd_r[k];
      nxt.mrem     = rm[DEN_W:1];
      nxt.vrem     = rv[DEN_W:1];
      nxt.mq       = {cd_r[k].mq[DW-2:0], rm[0]};
      nxt.vq       = {cd_r[k].vq[DW-2:0], rv[0]};
      nxt.mlow     = {cd_r[k].mlow[DW-2:0], 1'b0};
      nxt.vlow     = {cd_r[k].vlow[DW-2:0], 1'b0};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cd_r[k+1] <= '0;
      end else if (en) begin
        cd_r[k+1] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Clip the corrected moments (no flag), form lr*|mhat| and start the root of vhat << F.
  // ---------------------------------------------------------------------------------------------
  sqrt_t         sq_r [0:RW];
  sqrt_t         sq0_nxt;
  logic [DW-1:0] mh_mag, vhat, mcap;
  logic          mclip;

  always_comb begin
    mcap   = cd_r[DW].side.neg ? S_MIN : S_MAX;
    mclip  = cd_r[DW].mov || (cd_r[DW].mq > mcap);
    mh_mag = mclip ? mcap : cd_r[DW].mq;
    vhat   = cd_r[DW].vov ? '1 : cd_r[DW].vq;
    sq0_nxt.side = cd_r[DW].side;
    sq0_nxt.num  = lr_r * mh_mag;
    sq0_nxt.rad  = {vhat, {FRAC_BITS{1'b0}}};
    sq0_nxt.rem  = '0;
    sq0_nxt.root = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r[0] <= '0;
    end else if (en) begin
      sq_r[0] <= sq0_nxt;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    sqrt_t           nxt;
    logic [2*RW+1:0] st;

    always_comb begin
      st       = sqrt_step(sq_r[k].rem, sq_r[k].root, sq_r[k].rad[2*RW-1 -: 2]);
      nxt      = sq_r[k];
      nxt.rem  = st[2*RW+1:RW];
      nxt.root = st[RW-1:0];
      nxt.rad  = {sq_r[k].rad[2*RW-3:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_r[k+1] <= '0;
      end else if (en) begin
        sq_r[k+1] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Step divide: delta = lr*|mhat| / (root + eps). A quotient of 2^32 or more clips the weight
  // whatever its value, so it is carried as a single overflow bit.
  // ---------------------------------------------------------------------------------------------
  fdiv_t                fd0_nxt;
  logic [NUM_W-DW-1:0]  nhi;

  always_comb begin
    nhi          = sq_r[RW].num[NUM_W-1:DW];
    fd0_nxt.side = sq_r[RW].side;
    fd0_nxt.den  = DEN_W'(sq_r[RW].root) + DEN_W'(eps_r);
    fd0_nxt.dz   = (fd0_nxt.den == '0);
    fd0_nxt.ov   = DEN_W'(nhi) >= fd0_nxt.den;
    fd0_nxt.rem  = fd0_nxt.ov ? '0 : DEN_W'(nhi);
    fd0_nxt.low  = sq_r[RW].num[DW-1:0];
    fd0_nxt.q    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fd_r[0] <= '0;
    end else if (en) begin
      fd_r[0] <= fd0_nxt;
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_fdiv
    fdiv_t          nxt;
    logic [DEN_W:0] rs;

    always_comb begin
      rs      = div_step(fd_r[k].rem, fd_r[k].low[DW-1], fd_r[k].den);
      nxt     = fd_r[k];
      nxt.rem = rs[DEN_W:1];
      nxt.q   = {fd_r[k].q[DW-2:0], rs[0]};
      nxt.low = {fd_r[k].low[DW-2:0], 1'b0};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        fd_r[k+1] <= '0;
      end else if (en) begin
        fd_r[k+1] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Weight update and output register. Unused mode and zero denominator leave the weight alone.
  // ---------------------------------------------------------------------------------------------
  logic [DW:0]          dmag;
  logic signed [DW+1:0] sdelta, wd;
  logic                 wsat;
  logic [DW-1:0]        wnew;
  logic [DW-1:0]        ow_r, om_r, ov_r;
  logic                 osat_r;

  always_comb begin
    case (fd_r[DW].side.mode)
      MODE_SGD:     dmag = {1'b0, fd_r[DW].side.d0};
      MODE_RMSPROP,
      MODE_ADAM:    dmag = fd_r[DW].dz ? '0 :
                           (fd_r[DW].ov ? {1'b1, {DW{1'b0}}} : {1'b0, fd_r[DW].q});
      default:      dmag = '0;
    endcase
    sdelta = fd_r[DW].side.neg ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
    wd     = $signed({{2{fd_r[DW].side.w[DW-1]}}, fd_r[DW].side.w}) - sdelta;
    wsat   = (wd > $signed((DW+2)'(S_MAX))) || (wd < -$signed((DW+2)'(S_MIN)));
    if (wd > $signed((DW+2)'(S_MAX))) begin
      wnew = S_MAX;
    end else if (wd < -$signed((DW+2)'(S_MIN))) begin
      wnew = S_MIN;
    end else begin
      wnew = wd[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= fd_r[DW].side.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      ow_r   <= wnew;
      om_r   <= fd_r[DW].side.m_out;
      ov_r   <= fd_r[DW].side.v_out;
      osat_r <= fd_r[DW].side.flg | wsat;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_new_weight        = ow_r;
  assign out_new_first_moment  = om_r;
  assign out_new_second_moment = ov_r;
  assign out_saturated         = osat_r;

  // ---------------------------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------------------------
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input held off without an output stall");

  a_pow_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (pow1_r <= ONE_Q) && (pow2_r <= ONE_Q))
    else $error("beta power above one");

  a_pow_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready) |=> ($stable(pow1_r) && $stable(pow2_r)))
    else $error("beta power moved without a transfer");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_new_weight == S_MAX || out_new_weight == S_MIN ||
       out_new_first_moment == S_MAX || out_new_first_moment == S_MIN ||
       out_new_second_moment == '1))
    else $error("saturated set with no value at a limit");

  a_stall_freezes_tail: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(fd_r[DW].side.vld) && $stable(ow_r)))
    else $error("pipe tail moved during a stall");

endmodule

// ===== bench/gradient_optimizer_update_test.sv =====
// Self-checking bench for the SGD / RMSProp / Adam optimizer update engine.
// Depends on gou_pkg (mode enum, FRAC_BITS and CW) and gradient_optimizer_update.
`timescale 1ns / 1ps

module gradient_optimizer_update_test;
  import gou_pkg::*;

  localparam longint unsigned UNIT = 64'd1 << FRAC_BITS;   // 1.0 in Q.24
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 165;
  localparam int CALM_PHASES  = 2;      // last phases run without any idling
  localparam int DRAIN_CYCLES = 120;    // pipeline is 100 deep
  localparam int HOLD_AT_SENT = 530;    // early in a phase, far from any register write

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_weight = '0;
  logic signed [31:0] in_gradient = '0;
  logic signed [31:0] in_first_moment = '0;
  logic [31:0] in_second_moment = '0;
  logic in_first_of_step = 1'b0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic signed [31:0] out_new_weight;
  logic signed [31:0] out_new_first_moment;
  logic [31:0] out_new_second_moment;
  logic out_saturated;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;

  gradient_optimizer_update dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  typedef struct packed {
    logic [31:0] w;
    logic [31:0] m;
    logic [31:0] v;
    logic sat;
  } upd_t;

  typedef struct packed {
    mode_t md;
    logic [31:0] w, g, m, v;
    logic fs;
    logic known;    // expected result typed in below
    upd_t res;
  } dir_row_t;

  // shadow of the register file and the running beta powers
  mode_t cur_mode;
  longint unsigned lr_q, eps_q, rho_q, b1_q, b2_q, b1_pow, b2_pow;

  upd_t pending_updates[$];
  int errors = 0;
  int received = 0;
  int sent = 0;
  bit calm = 1'b0;

  // ---------------------------------------------------------------- predictor
  function automatic longint sx32(logic [31:0] x);
    return longint'($signed(x));
  endfunction

  function automatic longint unsigned mag(longint x);
    return (x < 0) ? longint'(-x) : x;
  endfunction

  // shift out the fraction, truncating toward zero
  function automatic longint drop_frac(longint x);
    longint r;
    r = longint'(mag(x) >> FRAC_BITS);
    return (x < 0) ? -r : r;
  endfunction

  function automatic longint div_trunc(longint num, longint unsigned den);
    longint r;
    r = longint'(mag(num) / den);
    return (num < 0) ? -r : r;
  endfunction

  function automatic longint clip_s32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint unsigned clip_u32(longint unsigned x);
    return (x > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : x;
  endfunction

  function automatic longint unsigned clamp_one(longint unsigned d);
    return (d > UNIT) ? UNIT : d;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // d*acc + (1-d)*g^2
  function automatic longint unsigned leaky_square(longint unsigned acc, longint g,
                                                   longint unsigned d);
    longint unsigned sq;
    sq = (mag(g) * mag(g)) >> FRAC_BITS;
    return (d * acc + (UNIT - d) * sq) >> FRAC_BITS;
  endfunction

  // lr*x / (sqrt(s)+eps); zero when the denominator vanishes
  function automatic longint root_scaled_step(longint x, longint unsigned s);
    longint unsigned den;
    den = int_sqrt(s << FRAC_BITS) + eps_q;
    if (den == 0) return 0;
    return div_trunc(longint'(lr_q) * x, den);
  endfunction

  function automatic upd_t predict_update(logic [31:0] w_in, logic [31:0] g_in,
                                          logic [31:0] m_in, logic [31:0] v_in, logic fs);
    longint w, g, m, delta, mhat, t;
    longint unsigned v, d, b1, b2, c1, c2, vhat, tu;
    logic flg;
    upd_t r;
    w = sx32(w_in);
    g = sx32(g_in);
    m = sx32(m_in);
    v = v_in;
    flg = 1'b0;
    delta = 0;
    case (cur_mode)
      MODE_SGD: delta = drop_frac(longint'(lr_q) * g);
      MODE_RMSPROP: begin
        d = clamp_one(rho_q);
        tu = leaky_square(v, g, d);
        v = clip_u32(tu);
        flg |= (v != tu);
        delta = root_scaled_step(g, v);
      end
      MODE_ADAM: begin
        b1 = clamp_one(b1_q);
        b2 = clamp_one(b2_q);
        if (fs) begin
          b1_pow = (b1_pow * b1) >> FRAC_BITS;
          b2_pow = (b2_pow * b2) >> FRAC_BITS;
        end
        t = drop_frac(longint'(b1) * m + longint'(UNIT - b1) * g);
        m = clip_s32(t);
        flg |= (m != t);
        tu = leaky_square(v, g, b2);
        v = clip_u32(tu);
        flg |= (v != tu);
        c1 = UNIT - b1_pow;
        c2 = UNIT - b2_pow;
        if (c1 == 0) c1 = UNIT;   // no step yet, or decay of one
        if (c2 == 0) c2 = UNIT;
        mhat = clip_s32(div_trunc(m * longint'(UNIT), c1));   // internal clips: no flag
        vhat = clip_u32((v * UNIT) / c2);
        delta = root_scaled_step(mhat, vhat);
      end
      default: ;                  // unused mode passes through
    endcase
    t = clip_s32(w - delta);
    flg |= (t != w - delta);
    r.w = t[31:0];
    r.m = m[31:0];
    r.v = v[31:0];
    r.sat = flg;
    return r;
  endfunction

  // ---------------------------------------------------------------- result check
  always @(posedge clk) begin
    upd_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      received++;
      if (pending_updates.size() == 0) begin
        errors++;
        $display("%0t: unexpected result w=%h m=%h v=%h sat=%b", $time, out_new_weight,
                 out_new_first_moment, out_new_second_moment, out_saturated);
      end else begin
        exp_r = pending_updates.pop_front();
        if (out_new_weight !== exp_r.w) begin
          errors++;
          $display("%0t: new_weight expected %h actual %h", $time, exp_r.w, out_new_weight);
        end
        if (out_new_first_moment !== exp_r.m) begin
          errors++;
          $display("%0t: new_first_moment expected %h actual %h", $time, exp_r.m,
                   out_new_first_moment);
        end
        if (out_new_second_moment !== exp_r.v) begin
          errors++;
          $display("%0t: new_second_moment expected %h actual %h", $time, exp_r.v,
                   out_new_second_moment);
        end
        if (out_saturated !== exp_r.sat) begin
          errors++;
          $display("%0t: saturated expected %b actual %b", $time, exp_r.sat, out_saturated);
        end
      end
    end
  end

  // receiver backpressure: random bursts plus one long hold-off to fill the pipe
  int ready_hold = 0;
  bit long_hold_done = 1'b0;
  always @(posedge clk) begin
    if (!long_hold_done && sent >= HOLD_AT_SENT) begin
      long_hold_done <= 1'b1;
      ready_hold <= 300;
      out_ready <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready <= (ready_hold == 1);
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      ready_hold <= $urandom_range(1, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic offer(logic [31:0] w, logic [31:0] g, logic [31:0] m, logic [31:0] v,
                       logic fs, logic known, upd_t typed);
    upd_t p;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_weight <= w;
    in_gradient <= g;
    in_first_moment <= m;
    in_second_moment <= v;
    in_first_of_step <= fs;
    do @(posedge clk); while (!in_ready);
    sent++;
    p = predict_update(w, g, m, v, fs);   // always run: keeps beta powers in step
    pending_updates.push_back(known ? typed : p);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_updates.size() != 0);
  endtask

  // block is idle here; write the whole register file
  task automatic write_regs(mode_t md, logic [23:0] lr, logic [23:0] eps, logic [23:0] rho,
                            logic [23:0] b1, logic [23:0] b2);
    logic [23:0] vals[6];
    vals = '{24'(md), lr, eps, rho, b1, b2};
    wait_drained();
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_mode = md;
    lr_q = lr;
    eps_q = eps;
    rho_q = rho;
    b1_q = b1;
    b2_q = b2;
  endtask

  function automatic logic [31:0] pick_value(bit unsigned_field);
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4: return $urandom;
      default: return unsigned_field ? 32'($urandom_range(0, 32'h0800_0000))
                                     : 32'($signed($urandom_range(0, 32'h0800_0000)) -
                                           32'sh0400_0000);
    endcase
  endfunction

  function automatic logic [23:0] pick_decay();
    case ($urandom_range(0, 5))
      0: return 24'($urandom);
      1: return 24'hFFFFFF;
      default: return 24'($urandom_range(14000000, 16777216));
    endcase
  endfunction

  // directed rows, at reset settings apart from the mode
  dir_row_t dir_rows[0:13] = '{
    '{MODE_SGD, 32'h0, 32'h0, 32'd123, 32'd456, 1'b0, 1'b1, '{32'h0, 32'd123, 32'd456, 1'b0}},
    '{MODE_SGD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 1'b1,
      '{32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1}},
    '{MODE_SGD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 1'b1,
      '{32'h8000_0000, 32'h0, 32'h0, 1'b1}},
    // step marker outside adam is ignored
    '{MODE_SGD, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1, '{32'h0, 32'h0, 32'h0, 1'b0}},
    '{MODE_SGD, 32'h0100_0000, 32'hFF00_0000, 32'h0, 32'h0, 1'b0, 1'b0, '0},
    // unused mode: straight pass, powers left alone
    '{MODE_PASS, 32'h1234_5678, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1,
      '{32'h1234_5678, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0}},
    '{MODE_RMSPROP, 32'h0100_0000, 32'h0, 32'd5, 32'h0, 1'b1, 1'b1,
      '{32'h0100_0000, 32'd5, 32'h0, 1'b0}},
    '{MODE_RMSPROP, 32'h0, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{MODE_RMSPROP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 1'b0, '0},
    // adam before any step: no bias correction
    '{MODE_ADAM, 32'h0, 32'h0100_0000, 32'h0, 32'h0, 1'b0, 1'b0, '0},
    '{MODE_ADAM, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, '0},
    '{MODE_ADAM, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0, 1'b0, '0},
    '{MODE_ADAM, 32'h0, 32'h0004_0000, 32'h0, 32'h0, 1'b1, 1'b0, '0},
    '{MODE_ADAM, 32'hFF00_0000, 32'hFFF0_0000, 32'h0001_0000, 32'h0000_1000, 1'b0, 1'b0, '0}
  };

  initial begin
    mode_t md;
    logic [23:0] lr, eps, rho, b1, b2;
    logic fs;
    cur_mode = MODE_SGD;
    lr_q = 16777;
    eps_q = 1;
    rho_q = 15099494;
    b1_q = 15099494;
    b2_q = 16760439;
    b1_pow = UNIT;
    b2_pow = UNIT;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].md != cur_mode)
        write_regs(dir_rows[i].md, 24'd16777, 24'd1, 24'd15099494, 24'd15099494,
                   24'd16760439);
      offer(dir_rows[i].w, dir_rows[i].g, dir_rows[i].m, dir_rows[i].v, dir_rows[i].fs,
            dir_rows[i].known, dir_rows[i].res);
    end

    for (int p = 0; p < PHASES; p++) begin
      md = (p < 8) ? mode_t'(p % 4) : (($urandom_range(0, 2) == 0) ? MODE_RMSPROP : MODE_ADAM);
      case (p)
        0: begin lr = 24'hFFFFFF; eps = 24'h0; rho = 24'h0; b1 = 24'h0; b2 = 24'h0; end
        1: begin lr = 24'h0; eps = 24'hFFFFFF; rho = 24'hFFFFFF; b1 = 24'hFFFFFF;
                 b2 = 24'hFFFFFF; end
        default: begin
          lr = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(1, 200000));
          eps = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 1000));
          rho = pick_decay();
          b1 = pick_decay();
          b2 = pick_decay();
        end
      endcase
      // sender waits for an empty pipe here before the writes
      write_regs(md, lr, eps, rho, b1, b2);
      calm = (p >= PHASES - CALM_PHASES);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // mostly well-formed adam steps of 16 elements, some stray markers
        fs = ((k % 16) == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 30) == 0);
        offer(pick_value(1'b0), pick_value(1'b0), pick_value(1'b0), pick_value(1'b1), fs,
              1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== gradient_optimizer_update.f =====
design/gou_pkg.sv
design/gradient_optimizer_update.sv
bench/gradient_optimizer_update_test.sv
